// ===== rtl/linear_distance_attenuation_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef LINEAR_DISTANCE_ATTENUATION_MACROS_SVH
`define LINEAR_DISTANCE_ATTENUATION_MACROS_SVH

// Same-cycle implication, clocked on clk and quiet while rst_n is low.
`define LDA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and quiet while rst_n is low.
`define LDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lda_pkg.sv =====
package lda_pkg;

    // Configuration port.
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FUNCTION  = 3'd0,
        CFG_SHAPE     = 3'd1,
        CFG_EMISSION  = 3'd2,
        CFG_INNER     = 3'd3,
        CFG_FALLOFF   = 3'd4,
        CFG_THRESHOLD = 3'd5
    } cfg_index_t;

    // Register widths.
    localparam int VOL_CFG_W = 17;
    localparam int RADIUS_W  = 24;

    // Reset values.
    localparam logic [VOL_CFG_W-1:0] EMISSION_RESET = 17'd65536;
    localparam logic [RADIUS_W-1:0]  FALLOFF_RESET  = 24'd256;

    // One metre in Q16.8.
    localparam logic [RADIUS_W:0] ONE_METRE = 25'd256;

    // Axis differences are limited to 2^25 before squaring.
    localparam int MAG_W   = 26;
    localparam int SQ_W    = 2 * MAG_W - 1;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int SQREM_W = ROOT_W + 2;

    // Effective falloff and the spans derived from it.
    localparam int SPAN_W = RADIUS_W + 1;

endpackage

// ===== rtl/linear_distance_attenuation.sv =====
// Channel | Direction | Handshake          | Payload
// in      | request   | in_valid/in_stall  | playing, source_x/y/z, target_x/y/z
// out     | result    | out_valid/out_stall| volume, detected, invalid
// cfg     | write     | cfg_we             | cfg_index, cfg_wdata
//
// One request enters every cycle while in_stall is low; the depth is set by the
// bit-per-stage square root (26 steps) and divider (one quotient bit a stage).
// The whole pipeline advances together; in_stall is high exactly while out holds a
// result that is stalled, and nothing in flight moves or is lost during that time.
// Reset is asynchronous and active low; it clears the valid bits and loads the
// register reset values.
module linear_distance_attenuation
    import lda_pkg::*;
#(
    parameter int POS_WIDTH        = 24,
    parameter int VOLUME_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          playing,
    input  logic signed [POS_WIDTH-1:0]   source_x,
    input  logic signed [POS_WIDTH-1:0]   source_y,
    input  logic signed [POS_WIDTH-1:0]   source_z,
    input  logic signed [POS_WIDTH-1:0]   target_x,
    input  logic signed [POS_WIDTH-1:0]   target_y,
    input  logic signed [POS_WIDTH-1:0]   target_z,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [VOLUME_FRAC_BITS:0]     volume,
    output logic                          detected,
    output logic                          invalid
);

    localparam int DIFF_W = POS_WIDTH + 1;
    localparam int AW     = (DIFF_W > MAG_W) ? DIFF_W : MAG_W;
    localparam int EW     = VOLUME_FRAC_BITS + 1;
    localparam int CW     = (EW > VOL_CFG_W) ? EW : VOL_CFG_W;
    localparam int QW     = VOLUME_FRAC_BITS;
    localparam int NUM_W  = QW + SPAN_W;
    localparam int PROD_W = EW + SPAN_W;

    // Configuration registers.
    logic                 function_reg;
    logic                 shape_reg;
    logic [VOL_CFG_W-1:0] emission_reg;
    logic [RADIUS_W-1:0]  inner_reg;
    logic [RADIUS_W-1:0]  falloff_reg;
    logic [VOL_CFG_W-1:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            function_reg  <= 1'b1;
            shape_reg     <= 1'b1;
            emission_reg  <= EMISSION_RESET;
            inner_reg     <= '0;
            falloff_reg   <= FALLOFF_RESET;
            threshold_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FUNCTION:  function_reg  <= cfg_wdata[0];
                CFG_SHAPE:     shape_reg     <= cfg_wdata[0];
                CFG_EMISSION:  emission_reg  <= cfg_wdata[VOL_CFG_W-1:0];
                CFG_INNER:     inner_reg     <= cfg_wdata;
                CFG_FALLOFF:   falloff_reg   <= cfg_wdata;
                CFG_THRESHOLD: threshold_reg <= cfg_wdata[VOL_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Register-derived; user must change regs only while pipeline is empty; unenforced.
    logic [CW-1:0]     emis_ext;
    logic [CW-1:0]     vol_one_ext;
    logic [CW-1:0]     e_full;
    logic [EW-1:0]     e_vol;
    logic [SPAN_W-1:0] f_eff;
    logic [SPAN_W-1:0] r_ext;

    always_comb
    begin
        emis_ext    = CW'(emission_reg);
        vol_one_ext = CW'(1) << VOLUME_FRAC_BITS;
        e_full      = (emis_ext > vol_one_ext) ? vol_one_ext : emis_ext;
        e_vol       = e_full[EW-1:0];
        r_ext       = SPAN_W'(inner_reg);
        f_eff       = (falloff_reg <= inner_reg) ? (r_ext + ONE_METRE)
                                                 : SPAN_W'(falloff_reg);
    end

    // Global advance: the pipeline moves unless a finished result is stalled.
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Stage 1: axis differences.
    logic                     s1_valid_reg;
    logic                     s1_play_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_play_reg    <= playing;
            s1_diff_reg[0] <= DIFF_W'(source_x) - DIFF_W'(target_x);
            s1_diff_reg[1] <= DIFF_W'(source_y) - DIFF_W'(target_y);
            s1_diff_reg[2] <= DIFF_W'(source_z) - DIFF_W'(target_z);
        end
    end

    // Stage 2: magnitudes, limited to the axis bound.
    logic             s2_valid_reg;
    logic             s2_play_reg;
    logic [MAG_W-1:0] s2_mag_reg [3];
    logic [MAG_W-1:0] s2_mag_next [3];

    always_comb
    begin
        logic [AW-1:0] mag_full;
        logic [AW-1:0] limit;
        limit = AW'(1) << (MAG_W - 1);
        for (int a = 0; a < 3; a++)
        begin
            mag_full = s1_diff_reg[a][DIFF_W-1] ? AW'(-s1_diff_reg[a])
                                                : AW'(s1_diff_reg[a]);
            mag_full = AW'(mag_full[DIFF_W-1:0]);
            s2_mag_next[a] = (mag_full > limit) ? limit[MAG_W-1:0] : mag_full[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_play_reg <= s1_play_reg;
            s2_mag_reg  <= s2_mag_next;
        end
    end

    // Stage 3: squares.
    logic            s3_valid_reg;
    logic            s3_play_reg;
    logic [SQ_W-1:0] s3_sq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_play_reg <= s2_play_reg;
            for (int a = 0; a < 3; a++)
            begin
                s3_sq_reg[a] <= SQ_W'(s2_mag_reg[a] * s2_mag_reg[a]);
            end
        end
    end

    // Square root, one result bit per stage; stage 0 is loaded with the sum of squares.
    logic               sq_valid_reg [ROOT_W+1];
    logic               sq_play_reg  [ROOT_W+1];
    logic [SUM_W-1:0]   sq_n_reg     [ROOT_W+1];
    logic [SQREM_W-1:0] sq_rem_reg   [ROOT_W+1];
    logic [ROOT_W-1:0]  sq_root_reg  [ROOT_W+1];
    logic [SUM_W-1:0]   sq_n_next    [ROOT_W];
    logic [SQREM_W-1:0] sq_rem_next  [ROOT_W];
    logic [ROOT_W-1:0]  sq_root_next [ROOT_W];

    always_comb
    begin
        logic [SQREM_W+1:0] t;
        logic [SQREM_W+1:0] trial;
        logic               ge;
        for (int k = 0; k < ROOT_W; k++)
        begin
            t     = {sq_rem_reg[k], sq_n_reg[k][SUM_W-1 -: 2]};
            trial = (SQREM_W+2)'({sq_root_reg[k], 2'b01});
            ge    = (t >= trial);
            sq_rem_next[k]  = ge ? SQREM_W'(t - trial) : SQREM_W'(t);
            sq_root_next[k] = {sq_root_reg[k][ROOT_W-2:0], ge};
            sq_n_next[k]    = sq_n_reg[k] << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ROOT_W; k++)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            sq_valid_reg[0] <= s3_valid_reg;
            for (int k = 0; k < ROOT_W; k++)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_play_reg[0] <= s3_play_reg;
            sq_n_reg[0]    <= SUM_W'(s3_sq_reg[0]) + SUM_W'(s3_sq_reg[1])
                            + SUM_W'(s3_sq_reg[2]);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 0; k < ROOT_W; k++)
            begin
                sq_play_reg[k+1] <= sq_play_reg[k];
                sq_n_reg[k+1]    <= sq_n_next[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
            end
        end
    end

    // Region compare against the inner radius and the effective falloff.
    logic              sa_valid_reg;
    logic              sa_play_reg;
    logic              sa_near_reg;
    logic              sa_far_reg;
    logic [SPAN_W-1:0] sa_fd_reg;
    logic [SPAN_W-1:0] sa_fr_reg;
    logic [ROOT_W-1:0] root_dist;

    assign root_dist = sq_root_reg[ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sa_valid_reg <= sq_valid_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_play_reg <= sq_play_reg[ROOT_W];
            sa_near_reg <= (root_dist <= ROOT_W'(inner_reg));
            sa_far_reg  <= (root_dist >= ROOT_W'(f_eff));
            sa_fd_reg   <= f_eff - root_dist[SPAN_W-1:0];
            sa_fr_reg   <= f_eff - r_ext;
        end
    end

    // Divider, one quotient bit per stage; stage 0 is loaded with E*(f-d).
    logic              dv_valid_reg [QW+1];
    logic              dv_play_reg  [QW+1];
    logic              dv_near_reg  [QW+1];
    logic              dv_far_reg   [QW+1];
    logic [SPAN_W-1:0] dv_div_reg   [QW+1];
    logic [SPAN_W-1:0] dv_rem_reg   [QW+1];
    logic [QW-1:0]     dv_low_reg   [QW+1];
    logic [QW-1:0]     dv_q_reg     [QW+1];
    logic [SPAN_W-1:0] dv_rem_next  [QW];
    logic [QW-1:0]     dv_low_next  [QW];
    logic [QW-1:0]     dv_q_next    [QW];
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num;

    assign prod = PROD_W'(e_vol) * PROD_W'(sa_fd_reg);
    assign num  = prod[NUM_W-1:0];

    always_comb
    begin
        logic [SPAN_W:0] t;
        logic            ge;
        for (int k = 0; k < QW; k++)
        begin
            t  = {dv_rem_reg[k], dv_low_reg[k][QW-1]};
            ge = (t >= (SPAN_W+1)'(dv_div_reg[k]));
            dv_rem_next[k] = ge ? SPAN_W'(t - (SPAN_W+1)'(dv_div_reg[k])) : SPAN_W'(t);
            dv_low_next[k] = dv_low_reg[k] << 1;
            dv_q_next[k]   = {dv_q_reg[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= sa_valid_reg;
            for (int k = 0; k < QW; k++)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_play_reg[0] <= sa_play_reg;
            dv_near_reg[0] <= sa_near_reg;
            dv_far_reg[0]  <= sa_far_reg;
            dv_div_reg[0]  <= sa_fr_reg;
            dv_rem_reg[0]  <= num[NUM_W-1:QW];
            dv_low_reg[0]  <= num[QW-1:0];
            dv_q_reg[0]    <= '0;
            for (int k = 0; k < QW; k++)
            begin
                dv_play_reg[k+1] <= dv_play_reg[k];
                dv_near_reg[k+1] <= dv_near_reg[k];
                dv_far_reg[k+1]  <= dv_far_reg[k];
                dv_div_reg[k+1]  <= dv_div_reg[k];
                dv_rem_reg[k+1]  <= dv_rem_next[k];
                dv_low_reg[k+1]  <= dv_low_next[k];
                dv_q_reg[k+1]    <= dv_q_next[k];
            end
        end
    end

    // Output stage: special cases, volume selection and detection.
    logic [EW-1:0] volume_reg;
    logic          detected_reg;
    logic          invalid_reg;
    logic [EW-1:0] volume_next;
    logic          detected_next;
    logic          invalid_next;

    always_comb
    begin
        volume_next  = '0;
        invalid_next = 1'b0;
        if (dv_play_reg[QW])
        begin
            if (!function_reg || !shape_reg)
            begin
                invalid_next = 1'b1;
            end
            else if (dv_near_reg[QW])
            begin
                volume_next = e_vol;
            end
            else if (!dv_far_reg[QW])
            begin
                volume_next = EW'(dv_q_reg[QW]);
            end
        end
        detected_next = (volume_next != '0) && (CW'(volume_next) >= CW'(threshold_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            volume_reg   <= volume_next;
            detected_reg <= detected_next;
            invalid_reg  <= invalid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign volume    = volume_reg;
    assign detected  = detected_reg;
    assign invalid   = invalid_reg;

endmodule

// ===== rtl/lda_checker.sv =====
`include "linear_distance_attenuation_macros.svh"

module lda_checker
#(
    parameter int VOLUME_FRAC_BITS = 16
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [VOLUME_FRAC_BITS:0] volume,
    input logic                      detected,
    input logic                      invalid
);

    localparam logic [VOLUME_FRAC_BITS:0] VOL_ONE = (VOLUME_FRAC_BITS+1)'(1) << VOLUME_FRAC_BITS;

    // A stalled result stays offered.
    `LDA_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "result dropped under stall")

    // The input side backs up exactly when a result is held.
    `LDA_ASSERT_SAME(a_stall_link, 1'b1, in_stall == (out_valid && out_stall), "stall mismatch")

    // An invalid request yields silence.
    `LDA_ASSERT_SAME(a_invalid_quiet, out_valid && invalid, volume == '0 && !detected, "invalid with volume")

    // Detection needs sound, and volume never exceeds one.
    `LDA_ASSERT_SAME(a_detect_range, out_valid, (!detected || volume != '0) && volume <= VOL_ONE, "volume range")

endmodule

bind linear_distance_attenuation lda_checker #(.VOLUME_FRAC_BITS(VOLUME_FRAC_BITS)) u_lda_checker (.*);
